>>> rtl/stwalk_pkg.sv
// Shared types and constants for the strided tensor address walker.
// No dependencies; stwalk_counter_cell and the top-level unit use this package.

package stwalk_pkg;

  // Configuration port geometry
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int RANK_BITS      = 3;
  localparam int BASE_BITS      = 48;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ACTIVE_RANK  = 3'd0,
    CFG_DIM_SIZES    = 3'd1,
    CFG_DIM_STRIDES  = 3'd2,
    CFG_SOURCE_BASE  = 3'd3,
    CFG_DEST_BASE    = 3'd4
  } cfg_reg_t;

  // Per-step control broadcast to every odometer cell
  typedef struct packed {
    logic step;      // a transaction is accepted this cycle
    logic restart;   // counters clear before this step
  } walk_ctl_t;

endpackage

>>> rtl/stwalk_counter_cell.sv
// One odometer cell: holds the counter of one dimension and ripples the carry.
// Depends on stwalk_pkg (walk_ctl_t).

module stwalk_counter_cell #(
  parameter int DIM_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stwalk_pkg::walk_ctl_t     ctl,
  input  logic                      active,
  input  logic [DIM_BITS-1:0]       size,
  input  logic                      carry_in,
  output logic                      carry_out,
  output logic [DIM_BITS-1:0]       coord
);

  logic [DIM_BITS-1:0] count;
  logic [DIM_BITS-1:0] count_eff;
  logic [DIM_BITS-1:0] count_next;
  logic [DIM_BITS:0]   incr;
  logic                at_final;

  // Effective value after an optional restart
  assign count_eff = ctl.restart ? '0 : count;
  assign incr      = {1'b0, count_eff} + {{DIM_BITS{1'b0}}, 1'b1};
  // Final when count+1 reaches or passes the size (size 0 is always final)
  assign at_final  = !(incr < {1'b0, size});

  // Inactive cells pass the carry untouched
  assign carry_out = active ? (carry_in & at_final) : carry_in;

  // Size-1 dimensions contribute coordinate zero
  assign coord = (active && (size != {{(DIM_BITS-1){1'b0}}, 1'b1})) ? count_eff : '0;

  // Odometer advance
  always_comb begin
    if (active && carry_in) begin
      count_next = at_final ? '0 : incr[DIM_BITS-1:0];
    end else begin
      count_next = count_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.step) begin
      count <= count_next;
    end
  end

endmodule

>>> rtl/stwalk_accum_cell.sv
// One accumulation cell: adds its dimension's coordinate times stride to the
// running source offset and hands the transaction to the next cell.
// Depends on nothing outside this file.

module stwalk_accum_cell #(
  parameter int MAX_RANK  = 4,
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 48,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  // upstream side
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DIM_BITS-1:0]  coords_in [MAX_RANK],
  input  logic [ADDR_BITS-1:0] sum_in,
  input  logic [ADDR_BITS-1:0] dest_in,
  input  logic                 last_in,
  input  logic [DIM_BITS-1:0]  stride,
  // downstream side
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DIM_BITS-1:0]  coords_out [MAX_RANK],
  output logic [ADDR_BITS-1:0] sum_out,
  output logic [ADDR_BITS-1:0] dest_out,
  output logic                 last_out
);

  logic [2*DIM_BITS-1:0] product;
  logic                  load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;
  assign product  = coords_in[CELL_IDX] * stride;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      coords_out <= coords_in;
      sum_out    <= sum_in + ADDR_BITS'(product);
      dest_out   <= dest_in;
      last_out   <= last_in;
    end
  end

endmodule

>>> rtl/strided_tensor_address_walker_unit.sv
// Top level of the strided tensor address walker: config registers, odometer
// cell row and accumulation cell row. Depends on stwalk_pkg,
// stwalk_counter_cell and stwalk_accum_cell.
//
// Usage:
//   Configure rank, packed sizes, packed strides and the two bases through the
//   write port (cfg_we, cfg_index, cfg_data) while the walker is idle.
//   Each input transaction (in_valid/in_ready, field restart) is one step and
//   yields one output transaction with source_address, dest_address and
//   last_element. restart=1 clears the counters and linear index first.
// Pipeline: one entry register, then one multiply-add cell per dimension,
//   between input accept and output valid.
// Throughput: one transaction per cycle while the output is not stalled; the
//   odometer carry ripples combinationally through the counter cells.
// Stall: each stage holds its transaction while the next stage is full, so
//   in_ready drops only once every stage holds a waiting transaction.
// Reset: rank 1, all sizes and strides 1, bases 0, counters and linear index
//   zero, pipeline empty.

module strided_tensor_address_walker_unit #(
  parameter int MAX_RANK  = 4,
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [stwalk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [stwalk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // step input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  restart,
  // address output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ADDR_BITS-1:0]                  source_address,
  output logic [ADDR_BITS-1:0]                  dest_address,
  output logic                                  last_element
);

  localparam int DATA_BITS = stwalk_pkg::CFG_DATA_BITS;

  // Reset pattern: a one in the low bit of each packed field that fits
  function automatic logic [DATA_BITS-1:0] ones_pattern();
    logic [DATA_BITS-1:0] acc;
    int                   shift;
    acc = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      shift = (MAX_RANK - 1 - i) * DIM_BITS;
      if (shift < DATA_BITS) begin
        acc[shift] = 1'b1;
      end
    end
    return acc;
  endfunction

  localparam logic [DATA_BITS-1:0] ONES = ones_pattern();

  // Configuration registers
  logic [stwalk_pkg::RANK_BITS-1:0] active_rank;
  logic [DATA_BITS-1:0]             dim_sizes_packed;
  logic [DATA_BITS-1:0]             dim_strides_packed;
  logic [stwalk_pkg::BASE_BITS-1:0] source_base;
  logic [stwalk_pkg::BASE_BITS-1:0] dest_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rank        <= stwalk_pkg::RANK_BITS'(1);
      dim_sizes_packed   <= ONES;
      dim_strides_packed <= ONES;
      source_base        <= '0;
      dest_base          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stwalk_pkg::CFG_ACTIVE_RANK: active_rank <= cfg_data[stwalk_pkg::RANK_BITS-1:0];
        stwalk_pkg::CFG_DIM_SIZES:   dim_sizes_packed   <= cfg_data;
        stwalk_pkg::CFG_DIM_STRIDES: dim_strides_packed <= cfg_data;
        stwalk_pkg::CFG_SOURCE_BASE: source_base <= cfg_data[stwalk_pkg::BASE_BITS-1:0];
        stwalk_pkg::CFG_DEST_BASE:   dest_base   <= cfg_data[stwalk_pkg::BASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Step control
  stwalk_pkg::walk_ctl_t ctl;
  logic                  stage0_valid;
  logic                  stage0_ready;

  assign in_ready    = stage0_ready;
  assign ctl.step    = in_valid && in_ready;
  assign ctl.restart = restart;

  // Per-dimension fields and odometer cell row
  logic [DIM_BITS-1:0] dim_size   [MAX_RANK];
  logic [DIM_BITS-1:0] dim_stride [MAX_RANK];
  logic [DIM_BITS-1:0] coord      [MAX_RANK];
  logic [MAX_RANK:0]   carry;
  logic                dim_active [MAX_RANK];

  assign carry[MAX_RANK] = 1'b1;

  for (genvar k = 0; k < MAX_RANK; k++) begin : g_dim
    localparam int SHIFT = (MAX_RANK - 1 - k) * DIM_BITS;
    logic [DATA_BITS-1:0] size_shifted;
    logic [DATA_BITS-1:0] stride_shifted;

    // Fields past bit 63 shift out to zero
    assign size_shifted   = dim_sizes_packed >> SHIFT;
    assign stride_shifted = dim_strides_packed >> SHIFT;
    assign dim_size[k]    = size_shifted[DIM_BITS-1:0];
    assign dim_stride[k]  = stride_shifted[DIM_BITS-1:0];

    // Rank 0 still enables dimension 0
    assign dim_active[k] = (k == 0) || ({1'b0, active_rank} > 4'(k));

    stwalk_counter_cell #(
      .DIM_BITS (DIM_BITS)
    ) u_cnt (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .active    (dim_active[k]),
      .size      (dim_size[k]),
      .carry_in  (carry[k+1]),
      .carry_out (carry[k]),
      .coord     (coord[k])
    );
  end

  // Linear index and destination address
  logic [ADDR_BITS-1:0] linear_index;
  logic [ADDR_BITS-1:0] linear_eff;
  logic [ADDR_BITS-1:0] linear_index_next;
  logic                 step_last;

  assign step_last         = carry[0];
  assign linear_eff        = restart ? '0 : linear_index;
  assign linear_index_next = step_last ? '0 : (linear_eff + ADDR_BITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_index <= '0;
    end else if (ctl.step) begin
      linear_index <= linear_index_next;
    end
  end

  // Entry register feeding the accumulation row
  logic [DIM_BITS-1:0]  stage0_coords [MAX_RANK];
  logic [ADDR_BITS-1:0] stage0_dest;
  logic                 stage0_last;
  logic [ADDR_BITS-1:0] src_base_ext;
  logic [ADDR_BITS-1:0] dst_base_ext;

  assign src_base_ext = ADDR_BITS'(source_base);
  assign dst_base_ext = ADDR_BITS'(dest_base);

  logic                 acc_valid [MAX_RANK+1];
  logic                 acc_ready [MAX_RANK+1];
  logic [DIM_BITS-1:0]  acc_coords [MAX_RANK+1][MAX_RANK];
  logic [ADDR_BITS-1:0] acc_sum  [MAX_RANK+1];
  logic [ADDR_BITS-1:0] acc_dest [MAX_RANK+1];
  logic                 acc_last [MAX_RANK+1];

  assign stage0_ready = !stage0_valid || acc_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage0_valid <= 1'b0;
    end else if (stage0_ready) begin
      stage0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      stage0_coords <= coord;
      stage0_dest   <= dst_base_ext + linear_eff;
      stage0_last   <= step_last;
    end
  end

  assign acc_valid[0]  = stage0_valid;
  assign acc_coords[0] = stage0_coords;
  assign acc_sum[0]    = src_base_ext;
  assign acc_dest[0]   = stage0_dest;
  assign acc_last[0]   = stage0_last;

  // Accumulation cell row, one multiply-add per dimension
  for (genvar k = 0; k < MAX_RANK; k++) begin : g_acc
    stwalk_accum_cell #(
      .MAX_RANK  (MAX_RANK),
      .DIM_BITS  (DIM_BITS),
      .ADDR_BITS (ADDR_BITS),
      .CELL_IDX  (k)
    ) u_acc (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (acc_valid[k]),
      .in_ready   (acc_ready[k]),
      .coords_in  (acc_coords[k]),
      .sum_in     (acc_sum[k]),
      .dest_in    (acc_dest[k]),
      .last_in    (acc_last[k]),
      .stride     (dim_stride[k]),
      .out_valid  (acc_valid[k+1]),
      .out_ready  (acc_ready[k+1]),
      .coords_out (acc_coords[k+1]),
      .sum_out    (acc_sum[k+1]),
      .dest_out   (acc_dest[k+1]),
      .last_out   (acc_last[k+1])
    );
  end

  // Output transaction comes from the last cell
  assign acc_ready[MAX_RANK] = out_ready;
  assign out_valid           = acc_valid[MAX_RANK];
  assign source_address      = acc_sum[MAX_RANK];
  assign dest_address        = acc_dest[MAX_RANK];
  assign last_element        = acc_last[MAX_RANK];

endmodule

>>> verif/tb_strided_tensor_address_walker_unit.sv
`timescale 1ns / 100ps
// Testbench for strided_tensor_address_walker_unit: directed and random address walks,
// each result checked against an in-bench odometer and address predictor.
// Depends on stwalk_pkg and the walker RTL.

module tb_strided_tensor_address_walker_unit;

  localparam int MAX_RANK       = 4;
  localparam int DIM_BITS       = 16;
  localparam int ADDR_BITS      = 48;
  localparam int PIPE_LATENCY   = MAX_RANK + 1;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_PRINTED    = 40;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [DIM_BITS-1:0]  dim_t;

  typedef struct {
    addr_t src;
    addr_t dst;
    logic  last;
  } walk_addr_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  cfg_we = 1'b0;
  logic [stwalk_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [stwalk_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic                                  restart = 1'b0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  addr_t                                 source_address;
  addr_t                                 dest_address;
  logic                                  last_element;

  strided_tensor_address_walker_unit #(
    .MAX_RANK (MAX_RANK),
    .DIM_BITS (DIM_BITS),
    .ADDR_BITS(ADDR_BITS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .source_address(source_address),
    .dest_address  (dest_address),
    .last_element  (last_element)
  );

  always #4 clk = ~clk;

  // Predictor copy of the registers and the walk state
  logic [stwalk_pkg::RANK_BITS-1:0] cur_rank;
  logic [63:0]                      cur_sizes;
  logic [63:0]                      cur_strides;
  addr_t                            cur_src_base;
  addr_t                            cur_dst_base;
  dim_t                             odo_count [MAX_RANK];
  addr_t                            elem_index;

  walk_addr_t pending_addrs [$];

  int mismatches      = 0;
  int steps_accepted  = 0;
  int addrs_checked   = 0;
  int lasts_seen      = 0;
  int configs_applied = 0;
  int quiet_cycles    = 0;
  bit tx_jitter       = 1'b0;
  bit rx_jitter       = 1'b0;
  int hold_token      = 0;
  int hold_seen       = 0;
  int rx_hold_left    = 0;
  int rx_stall_left   = 0;

  function automatic dim_t dim_field(logic [63:0] fields, int d);
    return fields[(MAX_RANK - 1 - d) * DIM_BITS +: DIM_BITS];
  endfunction

  // Addresses of the current element, then advance the odometer
  function automatic walk_addr_t next_walk_address(bit clear);
    walk_addr_t        res;
    int                rank;
    addr_t             offs;
    dim_t              sz;
    logic [DIM_BITS:0] nxt;
    bit                carry;
    rank = (cur_rank == 0) ? 1 : ((cur_rank > MAX_RANK) ? MAX_RANK : int'(cur_rank));
    if (clear) begin
      foreach (odo_count[d]) odo_count[d] = '0;
      elem_index = '0;
    end
    offs = '0;
    res.last = 1'b1;
    for (int d = 0; d < rank; d++) begin
      sz = dim_field(cur_sizes, d);
      // a size-1 dimension always sits at coordinate 0
      if (sz != 1)
        offs = offs + addr_t'(odo_count[d]) * addr_t'(dim_field(cur_strides, d));
      if ({1'b0, odo_count[d]} + 1 < {1'b0, sz}) res.last = 1'b0;
    end
    res.src = cur_src_base + offs;
    res.dst = cur_dst_base + elem_index;
    // innermost dimension first; a counter wraps to zero once count+1 reaches or passes its size
    carry = 1'b1;
    for (int d = rank - 1; d >= 0; d--) begin
      if (carry) begin
        nxt = {1'b0, odo_count[d]} + 1'b1;
        if (nxt < {1'b0, dim_field(cur_sizes, d)}) begin
          odo_count[d] = nxt[DIM_BITS-1:0];
          carry = 1'b0;
        end else begin
          odo_count[d] = '0;
        end
      end
    end
    elem_index = res.last ? addr_t'(0) : elem_index + 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, addrs_checked);
  endtask

  // Track register writes and accepted steps
  always @(posedge clk) begin
    if (rst) begin
      cur_rank     = stwalk_pkg::RANK_BITS'(1);
      cur_sizes    = {MAX_RANK{dim_t'(1)}};
      cur_strides  = {MAX_RANK{dim_t'(1)}};
      cur_src_base = '0;
      cur_dst_base = '0;
      foreach (odo_count[d]) odo_count[d] = '0;
      elem_index   = '0;
    end else begin
      if (in_valid && in_ready) begin
        pending_addrs.push_back(next_walk_address(restart));
        steps_accepted++;
      end
      if (cfg_we) begin
        case (stwalk_pkg::cfg_reg_t'(cfg_index))
          stwalk_pkg::CFG_ACTIVE_RANK:
            cur_rank = cfg_data[stwalk_pkg::RANK_BITS-1:0];
          stwalk_pkg::CFG_DIM_SIZES:   cur_sizes    = cfg_data;
          stwalk_pkg::CFG_DIM_STRIDES: cur_strides  = cfg_data;
          stwalk_pkg::CFG_SOURCE_BASE: cur_src_base = cfg_data[ADDR_BITS-1:0];
          stwalk_pkg::CFG_DEST_BASE:   cur_dst_base = cfg_data[ADDR_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    walk_addr_t want;
    if (!rst && out_valid && out_ready) begin
      addrs_checked++;
      if (pending_addrs.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(source_address), '0);
      end else begin
        want = pending_addrs.pop_front();
        if (source_address !== want.src)
          report_mismatch("source_address", 64'(source_address), 64'(want.src));
        if (dest_address !== want.dst)
          report_mismatch("dest_address", 64'(dest_address), 64'(want.dst));
        if (last_element !== want.last)
          report_mismatch("last_element", 64'(last_element), 64'(want.last));
        if (want.last) lasts_seen++;
      end
    end
  end

  // Receiver: long hold on request, otherwise random stall bursts when rx_jitter is set
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      rx_hold_left <= RX_HOLD_CYCLES - 1;
      out_ready    <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready     <= 1'b0;
    end else if (rx_jitter && $urandom_range(0, 9) == 0) begin
      rx_stall_left <= $urandom_range(0, 18);
      out_ready     <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", quiet_cycles);
      $display("tb_strided_tensor_address_walker_unit failed");
      $finish;
    end
  end

  // Offer one step and hold it until accepted; valid stays high afterwards
  task automatic send_step(bit clear);
    int gap;
    gap = 0;
    if (tx_jitter && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= clear;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_walker();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_addrs.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(stwalk_pkg::cfg_reg_t idx,
                           logic [stwalk_pkg::CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_config(logic [stwalk_pkg::RANK_BITS-1:0] rank, logic [63:0] sizes,
                            logic [63:0] strides, logic [63:0] src_base,
                            logic [63:0] dst_base);
    write_reg(stwalk_pkg::CFG_ACTIVE_RANK, 64'(rank));
    write_reg(stwalk_pkg::CFG_DIM_SIZES, sizes);
    write_reg(stwalk_pkg::CFG_DIM_STRIDES, strides);
    write_reg(stwalk_pkg::CFG_SOURCE_BASE, src_base);
    write_reg(stwalk_pkg::CFG_DEST_BASE, dst_base);
    cfg_we <= 1'b0;
    configs_applied++;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 64'(addr_t'('1));
      2:       return {$urandom, $urandom};  // upper bits must be dropped
      default: return 64'(addr_t'({$urandom, $urandom}));
    endcase
  endfunction

  // Mostly small walks so that they wrap often; sometimes extremes
  task automatic pick_walk_config();
    logic [63:0]                      sizes;
    logic [63:0]                      strides;
    logic [stwalk_pkg::RANK_BITS-1:0] rank;
    dim_t                             sz;
    dim_t                             st;
    for (int d = 0; d < MAX_RANK; d++) begin
      case ($urandom_range(0, 11))
        0:       sz = '0;
        1:       sz = '1;
        2:       sz = dim_t'($urandom);
        default: sz = dim_t'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       st = '0;
        1:       st = '1;
        default: st = dim_t'($urandom);
      endcase
      sizes[(MAX_RANK - 1 - d) * DIM_BITS +: DIM_BITS]   = sz;
      strides[(MAX_RANK - 1 - d) * DIM_BITS +: DIM_BITS] = st;
    end
    case ($urandom_range(0, 9))
      0:       rank = '0;
      1:       rank = stwalk_pkg::RANK_BITS'($urandom_range(MAX_RANK + 1, 7));
      default: rank = stwalk_pkg::RANK_BITS'($urandom_range(1, MAX_RANK));
    endcase
    set_config(rank, sizes, strides, pick_base(), pick_base());
  endtask

  // Reset registers: one dimension of size 1, every step is final
  task automatic test_reset_state();
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    drain_walker();
  endtask

  // Rank above the maximum, a zero-size and a size-1 dimension,
  // mostly full strides and bases near the top so both addresses wrap
  task automatic test_extreme_fields();
    set_config(3'd7, {16'h0002, 16'h0000, 16'h0001, 16'h0003},
               {16'hFFFF, 16'h1234, 16'hFFFF, 16'hFFFF},
               64'h0000_FFFF_FFFF_FFF0, 64'h0000_FFFF_FFFF_FFFE);
    repeat (4) send_step(1'b0);
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    drain_walker();
  endtask

  // Rank zero behaves as a single dimension
  task automatic test_rank_clamp();
    set_config(3'd0, {16'h0003, 16'h0005, 16'h0002, 16'h0002},
               {16'h0010, 16'h0100, 16'h1000, 16'h0001}, 64'h1000, 64'h2000);
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    drain_walker();
  endtask

  // Shrink a size mid-walk: the counter is past the new size,
  // so the next step is final and the counter wraps
  task automatic test_resized_walk();
    set_config(3'd1, {16'h0008, 48'h0}, {16'h0003, 48'h0}, 64'h100, 64'h200);
    send_step(1'b1);
    repeat (5) send_step(1'b0);
    drain_walker();
    set_config(3'd1, {16'h0003, 48'h0}, {16'h0003, 48'h0}, 64'h100, 64'h200);
    repeat (2) send_step(1'b0);
    drain_walker();
  endtask

  // Hold the output long enough that the pipeline fills and input stalls
  task automatic test_fill_and_stall();
    set_config(3'd2, {16'h0003, 16'h0005, 32'h0}, {16'h0040, 16'h0002, 32'h0},
               64'h8000, 64'h4000);
    hold_token <= hold_token + 1;
    repeat (40) send_step($urandom_range(0, 15) == 0);
    drain_walker();
  endtask

  // Random settings with random idling on both sides; counters carry over
  // between settings unless a restart comes along
  task automatic test_random_walks(int phases, int items);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    repeat (phases) begin
      pick_walk_config();
      repeat (items) send_step($urandom_range(0, 19) == 0);
      drain_walker();
    end
  endtask

  // Full-rate stretch with no idling at all
  task automatic test_final_burst(int items);
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    pick_walk_config();
    repeat (items) send_step($urandom_range(0, 19) == 0);
    drain_walker();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_extreme_fields();
    test_rank_clamp();
    test_resized_walk();
    test_fill_and_stall();
    test_random_walks(26, 64);
    test_final_burst(220);
    if (pending_addrs.size() != 0)
      report_mismatch("results never arrived", 64'(pending_addrs.size()), '0);
    $display("summary: %0d steps accepted, %0d results checked, %0d walk ends",
             steps_accepted, addrs_checked, lasts_seen);
    $display("summary: %0d register settings, incl. rank clamping, zero sizes, %s",
             configs_applied, "shrunk walks and a long output hold");
    if (mismatches == 0) begin
      $display("tb_strided_tensor_address_walker_unit passed");
    end else begin
      $display("tb_strided_tensor_address_walker_unit failed");
    end
    $finish;
  end

endmodule
